@@ rtl/gic_pkg.sv @@
// Shared types, register codes and constants for the gamepad input conditioner.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package gic_pkg;

   // Default sizing, handed to the top level parameters
   localparam int DEF_AXIS_BITS    = 16;
   localparam int DEF_BUTTON_COUNT = 16;

   // Fixed field widths
   localparam int FIELD_W    = 16;
   localparam int DZ_W       = 15;
   localparam int TRIG_W     = 8;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int NUM_LANES  = 4;

   // Deadzone limits
   localparam logic [DZ_W-1:0] DZ_MAX   = 15'd31129;
   localparam logic [DZ_W-1:0] DZ_RESET = 15'd4915;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DZ_H    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DZ_V    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_VIB_EN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MOTOR_L = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MOTOR_R = 3'd4;

   // Lane command: start strobe, raw axis, deadzone for its direction
   typedef struct packed {
      logic                      start;
      logic signed [FIELD_W-1:0] raw;
      logic [DZ_W-1:0]           dz;
   } lane_in_type;

   // Lane status: result ready, conditioned axis
   typedef struct packed {
      logic                      done;
      logic signed [FIELD_W-1:0] value;
   } lane_out_type;

   // Per-word fields that do not need the lanes
   typedef struct packed {
      logic               connected;
      logic [FIELD_W-1:0] left_trigger_level;
      logic [FIELD_W-1:0] right_trigger_level;
      logic [FIELD_W-1:0] pressed;
      logic [FIELD_W-1:0] held;
      logic [FIELD_W-1:0] released;
      logic [FIELD_W-1:0] left_motor;
      logic [FIELD_W-1:0] right_motor;
   } side_type;

   // Complete result word
   typedef struct packed {
      side_type                           side;
      logic [NUM_LANES-1:0][FIELD_W-1:0]  axis;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/gic_axis_lane.sv @@
// One stick-axis lane: clamp, deadzone test and rescale by a bit-serial divider.
// Depends on gic_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gic_axis_lane
   import gic_pkg::*;
#(
   parameter int AXIS_BITS = DEF_AXIS_BITS
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire lane_in_type  lane_in,
   input  wire logic         collect,
   output lane_out_type      lane_out
);

   localparam int W     = AXIS_BITS - 1;
   localparam int CNT_W = $clog2(W + 1);
   localparam logic [W-1:0] AXIS_MAX = {W{1'b1}};
   localparam logic [FIELD_W-1:0] AXIS_MAX_WIDE = {{(FIELD_W-W){1'b0}}, AXIS_MAX};
   localparam logic signed [FIELD_W:0] POS_LIM = $signed({1'b0, AXIS_MAX_WIDE});
   localparam logic signed [FIELD_W:0] NEG_LIM = -POS_LIM;

   logic signed [FIELD_W:0] raw_ext;
   logic signed [FIELD_W:0] clamped;
   logic signed [FIELD_W:0] mag_ext;
   logic                    neg;
   logic [W-1:0]            mag;
   logic [DZ_W-1:0]         dz_sat;
   logic [FIELD_W-1:0]      dz_wide;
   logic [FIELD_W-1:0]      mag_wide;
   logic                    zero;
   logic [W-1:0]            diff;
   logic [W-1:0]            den;
   logic [2*W-1:0]          num;

   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     den_ff, den_in;
   logic             neg_ff, neg_in;
   logic             zero_ff, zero_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [W:0]         trial;
   logic [W:0]         trial_sub;
   logic               ge;
   logic [FIELD_W-1:0] q_wide;

   // Setup: clamp, magnitude, deadzone saturation, numerator (d*AXIS_MAX as shift-subtract)
   always_comb begin
      raw_ext = {lane_in.raw[FIELD_W-1], lane_in.raw};
      if (raw_ext < NEG_LIM) begin
         clamped = NEG_LIM;
      end else if (raw_ext > POS_LIM) begin
         clamped = POS_LIM;
      end else begin
         clamped = raw_ext;
      end
      neg      = clamped[FIELD_W];
      mag_ext  = neg ? -clamped : clamped;
      mag      = mag_ext[W-1:0];
      dz_sat   = (lane_in.dz > DZ_MAX) ? DZ_MAX : lane_in.dz;
      dz_wide  = {1'b0, dz_sat};
      mag_wide = {{(FIELD_W-W){1'b0}}, mag};
      zero     = (dz_wide >= AXIS_MAX_WIDE) || (mag_wide < dz_wide);
      diff     = mag - dz_sat[W-1:0];
      den      = AXIS_MAX - dz_sat[W-1:0];
      num      = {diff, {W{1'b0}}} - {{W{1'b0}}, diff};
   end

   // One restoring-division step per cycle; quotient bits shift into the low word
   always_comb begin
      trial     = {rem_ff, quo_ff[W-1]};
      trial_sub = trial - {1'b0, den_ff};
      ge        = (trial >= {1'b0, den_ff});

      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;

      if (collect) begin
         done_in = 1'b0;
      end

      if (lane_in.start) begin
         rem_in  = num[2*W-1:W];
         quo_in  = num[W-1:0];
         den_in  = den;
         neg_in  = neg;
         zero_in = zero;
         cnt_in  = CNT_W'(W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in = ge ? trial_sub[W-1:0] : trial[W-1:0];
         quo_in = {quo_ff[W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

   // Apply sign, or zero inside the deadzone
   always_comb begin
      q_wide         = {{(FIELD_W-W){1'b0}}, quo_ff};
      lane_out.done  = done_ff;
      if (zero_ff) begin
         lane_out.value = '0;
      end else if (neg_ff) begin
         lane_out.value = -$signed(q_wide);
      end else begin
         lane_out.value = $signed(q_wide);
      end
   end

endmodule

`default_nettype wire

@@ rtl/gic_merge.sv @@
// Merge stage: waits for all axis lanes, combines them with the side fields
// into the output register. Depends on gic_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gic_merge
   import gic_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire lane_out_type [NUM_LANES-1:0] lane_out,
   input  wire side_type                     side,
   input  wire logic                         out_ready,
   output logic                              collect,
   output logic                              out_valid,
   output result_type                        result
);

   logic       all_done;
   logic       valid_ff, valid_in;
   result_type result_ff, result_in;

   // All lanes finished and the output register is free or draining
   always_comb begin
      all_done = 1'b1;
      for (int i = 0; i < NUM_LANES; i++) begin
         all_done = all_done & lane_out[i].done;
      end
      collect = all_done && (!valid_ff || out_ready);
   end

   // Output register next state
   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      if (collect) begin
         valid_in       = 1'b1;
         result_in.side = side;
         for (int i = 0; i < NUM_LANES; i++) begin
            result_in.axis[i] = side.connected ? lane_out[i].value : '0;
         end
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign out_valid = valid_ff;
   assign result    = result_ff;

endmodule

`default_nettype wire

@@ rtl/gamepad_input_conditioner.sv @@
// Gamepad input conditioner top level: config registers, button edges,
// triggers, four axis lanes and the merge stage. Depends on gic_pkg,
// gic_axis_lane and gic_merge.
//
// Usage:
//  - req_* channel (valid/ready) carries one controller poll per word.
//  - rsp_* channel (valid/ready) returns one conditioned word per poll.
//  - csr_* is a write-only port: csr_write_enable, csr_index, csr_write_data.
//    Write registers only while no poll is in flight.
//  - Each axis runs in its own lane, a bit-serial divider giving one
//    quotient bit per cycle.
//  - The lanes are the limiting loop: one poll is in the lanes at a time.
//  - The output register holds a finished word while the next poll runs;
//    if the receiver stalls, the lanes hold their result and req_ready
//    stays low until the output register is free.
//  - Reset restores the register defaults (deadzones 4915, vibration off,
//    motor levels 0), clears the previous buttons and empties the pipeline.
//  - A poll with link_ok low gives an all-zero word and clears the
//    previous buttons.
`timescale 1ns / 1ps
`default_nettype none

module gamepad_input_conditioner
   import gic_pkg::*;
#(
   parameter int AXIS_BITS    = DEF_AXIS_BITS,
   parameter int BUTTON_COUNT = DEF_BUTTON_COUNT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,

   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]      csr_index,
   input  wire logic [CSR_DATA_W-1:0]     csr_write_data,

   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_link_ok,
   input  wire logic signed [FIELD_W-1:0] req_raw_left_x,
   input  wire logic signed [FIELD_W-1:0] req_raw_left_y,
   input  wire logic signed [FIELD_W-1:0] req_raw_right_x,
   input  wire logic signed [FIELD_W-1:0] req_raw_right_y,
   input  wire logic [TRIG_W-1:0]         req_raw_left_trigger,
   input  wire logic [TRIG_W-1:0]         req_raw_right_trigger,
   input  wire logic [FIELD_W-1:0]        req_button_bits,

   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic                           rsp_connected,
   output logic signed [FIELD_W-1:0]      rsp_left_x_scaled,
   output logic signed [FIELD_W-1:0]      rsp_left_y_scaled,
   output logic signed [FIELD_W-1:0]      rsp_right_x_scaled,
   output logic signed [FIELD_W-1:0]      rsp_right_y_scaled,
   output logic [FIELD_W-1:0]             rsp_left_trigger_level,
   output logic [FIELD_W-1:0]             rsp_right_trigger_level,
   output logic [FIELD_W-1:0]             rsp_pressed_buttons,
   output logic [FIELD_W-1:0]             rsp_held_buttons,
   output logic [FIELD_W-1:0]             rsp_released_buttons,
   output logic [FIELD_W-1:0]             rsp_left_motor_drive,
   output logic [FIELD_W-1:0]             rsp_right_motor_drive
);

   localparam logic [FIELD_W-1:0] BTN_MASK =
      FIELD_W'((33'd1 << BUTTON_COUNT) - 33'd1);

   // Configuration registers
   logic [DZ_W-1:0]    dz_h_ff, dz_h_in;
   logic [DZ_W-1:0]    dz_v_ff, dz_v_in;
   logic               vib_en_ff, vib_en_in;
   logic [FIELD_W-1:0] motor_l_ff, motor_l_in;
   logic [FIELD_W-1:0] motor_r_ff, motor_r_in;

   // Word control and state
   logic               busy_ff, busy_in;
   logic [FIELD_W-1:0] prev_ff, prev_in;
   side_type           side_ff, side_in;
   logic               accept;
   logic [FIELD_W-1:0] cur;

   lane_in_type  [NUM_LANES-1:0] lane_in;
   lane_out_type [NUM_LANES-1:0] lane_out;
   logic                         collect;
   result_type                   result;

   // Register writes; unknown indexes are ignored
   always_comb begin
      dz_h_in    = dz_h_ff;
      dz_v_in    = dz_v_ff;
      vib_en_in  = vib_en_ff;
      motor_l_in = motor_l_ff;
      motor_r_in = motor_r_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_DZ_H:    dz_h_in    = csr_write_data[DZ_W-1:0];
            REG_DZ_V:    dz_v_in    = csr_write_data[DZ_W-1:0];
            REG_VIB_EN:  vib_en_in  = csr_write_data[0];
            REG_MOTOR_L: motor_l_in = csr_write_data;
            REG_MOTOR_R: motor_r_in = csr_write_data;
            default: ;
         endcase
      end
   end

   assign req_ready = !busy_ff;
   assign accept    = req_valid && req_ready;
   assign cur       = req_button_bits & BTN_MASK;

   // Capture the side fields and button history at accept
   always_comb begin
      busy_in = busy_ff;
      prev_in = prev_ff;
      side_in = side_ff;
      if (collect) begin
         busy_in = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
         if (req_link_ok) begin
            prev_in                     = cur;
            side_in.connected           = 1'b1;
            side_in.left_trigger_level  = {req_raw_left_trigger, req_raw_left_trigger};
            side_in.right_trigger_level = {req_raw_right_trigger, req_raw_right_trigger};
            side_in.pressed             = cur & ~prev_ff;
            side_in.held                = cur & prev_ff;
            side_in.released            = ~cur & prev_ff;
            side_in.left_motor          = vib_en_ff ? motor_l_ff : '0;
            side_in.right_motor         = vib_en_ff ? motor_r_ff : '0;
         end else begin
            prev_in = '0;
            side_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dz_h_ff    <= DZ_RESET;
         dz_v_ff    <= DZ_RESET;
         vib_en_ff  <= 1'b0;
         motor_l_ff <= '0;
         motor_r_ff <= '0;
         busy_ff    <= 1'b0;
         prev_ff    <= '0;
      end else begin
         dz_h_ff    <= dz_h_in;
         dz_v_ff    <= dz_v_in;
         vib_en_ff  <= vib_en_in;
         motor_l_ff <= motor_l_in;
         motor_r_ff <= motor_r_in;
         busy_ff    <= busy_in;
         prev_ff    <= prev_in;
      end
      side_ff <= side_in;
   end

   // Lane commands: X axes use the horizontal deadzone, Y axes the vertical
   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         lane_in[i].start = accept;
      end
      lane_in[0].raw = req_raw_left_x;
      lane_in[0].dz  = dz_h_ff;
      lane_in[1].raw = req_raw_left_y;
      lane_in[1].dz  = dz_v_ff;
      lane_in[2].raw = req_raw_right_x;
      lane_in[2].dz  = dz_h_ff;
      lane_in[3].raw = req_raw_right_y;
      lane_in[3].dz  = dz_v_ff;
   end

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      gic_axis_lane #(
         .AXIS_BITS (AXIS_BITS)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .lane_in  (lane_in[g]),
         .collect  (collect),
         .lane_out (lane_out[g])
      );
   end

   gic_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .lane_out  (lane_out),
      .side      (side_ff),
      .out_ready (rsp_ready),
      .collect   (collect),
      .out_valid (rsp_valid),
      .result    (result)
   );

   // Break the result word out to the ports
   assign rsp_connected           = result.side.connected;
   assign rsp_left_x_scaled       = $signed(result.axis[0]);
   assign rsp_left_y_scaled       = $signed(result.axis[1]);
   assign rsp_right_x_scaled      = $signed(result.axis[2]);
   assign rsp_right_y_scaled      = $signed(result.axis[3]);
   assign rsp_left_trigger_level  = result.side.left_trigger_level;
   assign rsp_right_trigger_level = result.side.right_trigger_level;
   assign rsp_pressed_buttons     = result.side.pressed;
   assign rsp_held_buttons        = result.side.held;
   assign rsp_released_buttons    = result.side.released;
   assign rsp_left_motor_drive    = result.side.left_motor;
   assign rsp_right_motor_drive   = result.side.right_motor;

endmodule

`default_nettype wire

@@ tb/gic_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the gamepad input conditioner: tracks the register writes,
// predicts one conditioned word per accepted poll and compares the rsp words.
// Depends on gic_pkg only.

module gic_checker
   import gic_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      csr_write_enable,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_write_data,

   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic                      req_link_ok,
   input  logic signed [FIELD_W-1:0] req_raw_left_x,
   input  logic signed [FIELD_W-1:0] req_raw_left_y,
   input  logic signed [FIELD_W-1:0] req_raw_right_x,
   input  logic signed [FIELD_W-1:0] req_raw_right_y,
   input  logic [TRIG_W-1:0]         req_raw_left_trigger,
   input  logic [TRIG_W-1:0]         req_raw_right_trigger,
   input  logic [FIELD_W-1:0]        req_button_bits,

   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic                      rsp_connected,
   input  logic signed [FIELD_W-1:0] rsp_left_x_scaled,
   input  logic signed [FIELD_W-1:0] rsp_left_y_scaled,
   input  logic signed [FIELD_W-1:0] rsp_right_x_scaled,
   input  logic signed [FIELD_W-1:0] rsp_right_y_scaled,
   input  logic [FIELD_W-1:0]        rsp_left_trigger_level,
   input  logic [FIELD_W-1:0]        rsp_right_trigger_level,
   input  logic [FIELD_W-1:0]        rsp_pressed_buttons,
   input  logic [FIELD_W-1:0]        rsp_held_buttons,
   input  logic [FIELD_W-1:0]        rsp_released_buttons,
   input  logic [FIELD_W-1:0]        rsp_left_motor_drive,
   input  logic [FIELD_W-1:0]        rsp_right_motor_drive,

   output int                        outstanding,
   output int                        failures
);

   localparam int AXIS_FULL = (1 << (DEF_AXIS_BITS - 1)) - 1;
   localparam logic [FIELD_W-1:0] BUTTON_MASK = FIELD_W'((1 << DEF_BUTTON_COUNT) - 1);

   typedef struct packed {
      logic                      connected;
      logic signed [FIELD_W-1:0] left_x;
      logic signed [FIELD_W-1:0] left_y;
      logic signed [FIELD_W-1:0] right_x;
      logic signed [FIELD_W-1:0] right_y;
      logic [FIELD_W-1:0]        left_trigger;
      logic [FIELD_W-1:0]        right_trigger;
      logic [FIELD_W-1:0]        pressed;
      logic [FIELD_W-1:0]        held;
      logic [FIELD_W-1:0]        released;
      logic [FIELD_W-1:0]        left_motor;
      logic [FIELD_W-1:0]        right_motor;
   } conditioned_word_type;

   // shadow registers and button history
   logic [DZ_W-1:0]    dz_horizontal;
   logic [DZ_W-1:0]    dz_vertical;
   logic               vib_enable;
   logic [FIELD_W-1:0] motor_left;
   logic [FIELD_W-1:0] motor_right;
   logic [FIELD_W-1:0] prev_buttons;

   conditioned_word_type  pending_words[$];

   // deadzone and rescale of one axis, truncated toward zero
   function automatic logic signed [FIELD_W-1:0] scale_axis(
      input logic signed [FIELD_W-1:0] raw,
      input logic [DZ_W-1:0]           dz_reg
   );
      int v;
      int dz;
      int mag;
      int q;
      v   = int'(raw);
      dz  = (dz_reg > DZ_MAX) ? int'(DZ_MAX) : int'(dz_reg);
      if (v < -AXIS_FULL) v = -AXIS_FULL;
      if (v > AXIS_FULL) v = AXIS_FULL;
      mag = (v < 0) ? -v : v;
      if (dz >= AXIS_FULL || mag < dz) return '0;
      q = ((mag - dz) * AXIS_FULL) / (AXIS_FULL - dz);
      return FIELD_W'((v < 0) ? -q : q);
   endfunction

   // expected word for the poll on the req ports; updates the button history
   function automatic conditioned_word_type condition_poll();
      conditioned_word_type w;
      logic [FIELD_W-1:0] cur;
      w = '0;
      if (!req_link_ok) begin
         prev_buttons = '0;
         return w;
      end
      cur             = req_button_bits & BUTTON_MASK;
      w.connected     = 1'b1;
      w.left_x        = scale_axis(req_raw_left_x, dz_horizontal);
      w.left_y        = scale_axis(req_raw_left_y, dz_vertical);
      w.right_x       = scale_axis(req_raw_right_x, dz_horizontal);
      w.right_y       = scale_axis(req_raw_right_y, dz_vertical);
      // raw * 257 is the byte repeated
      w.left_trigger  = {req_raw_left_trigger, req_raw_left_trigger};
      w.right_trigger = {req_raw_right_trigger, req_raw_right_trigger};
      w.pressed       = cur & ~prev_buttons;
      w.held          = cur & prev_buttons;
      w.released      = ~cur & prev_buttons & BUTTON_MASK;
      prev_buttons    = cur;
      if (vib_enable) begin
         w.left_motor  = motor_left;
         w.right_motor = motor_right;
      end
      return w;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   task automatic compare_word(input conditioned_word_type want);
      check_field("connected", want.connected, rsp_connected);
      check_field("left_x_scaled", want.left_x, rsp_left_x_scaled);
      check_field("left_y_scaled", want.left_y, rsp_left_y_scaled);
      check_field("right_x_scaled", want.right_x, rsp_right_x_scaled);
      check_field("right_y_scaled", want.right_y, rsp_right_y_scaled);
      check_field("left_trigger_level", want.left_trigger, rsp_left_trigger_level);
      check_field("right_trigger_level", want.right_trigger, rsp_right_trigger_level);
      check_field("pressed_buttons", want.pressed, rsp_pressed_buttons);
      check_field("held_buttons", want.held, rsp_held_buttons);
      check_field("released_buttons", want.released, rsp_released_buttons);
      check_field("left_motor_drive", want.left_motor, rsp_left_motor_drive);
      check_field("right_motor_drive", want.right_motor, rsp_right_motor_drive);
   endtask

   // sample both channels and the csr port at each edge
   always @(posedge clock) begin
      if (reset) begin
         dz_horizontal = DZ_RESET;
         dz_vertical   = DZ_RESET;
         vib_enable    = 1'b0;
         motor_left    = '0;
         motor_right   = '0;
         prev_buttons  = '0;
         failures      = 0;
         pending_words.delete();
      end else begin
         // compare first: a word leaving now belongs to an older poll
         if (rsp_valid && rsp_ready) begin
            if (pending_words.size() == 0) begin
               $error("rsp word accepted with no word expected");
               failures++;
            end else begin
               compare_word(pending_words.pop_front());
            end
         end
         if (req_valid && req_ready)
            pending_words.push_back(condition_poll());
         // out-of-range indexes fall through
         if (csr_write_enable) begin
            case (csr_index)
               REG_DZ_H:    dz_horizontal = csr_write_data[DZ_W-1:0];
               REG_DZ_V:    dz_vertical   = csr_write_data[DZ_W-1:0];
               REG_VIB_EN:  vib_enable    = csr_write_data[0];
               REG_MOTOR_L: motor_left    = csr_write_data[FIELD_W-1:0];
               REG_MOTOR_R: motor_right   = csr_write_data[FIELD_W-1:0];
               default: ;
            endcase
         end
      end
      outstanding <= pending_words.size();
   end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Top of the gamepad input conditioner bench: clock, reset, register phases,
// directed and random polls, receiver stalls and the verdict.
// Depends on gic_pkg, gamepad_input_conditioner and gic_checker.

module tb;
   import gic_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PHASE_COUNT  = 10;
   localparam int PHASE_ITEMS  = 135;
   localparam int DRAIN_CYCLES = 4 * DEF_AXIS_BITS;
   localparam logic [CSR_IDX_W-1:0] REG_PAST_END = REG_MOTOR_R + 1'b1;

   typedef struct {
      logic                      link;
      logic signed [FIELD_W-1:0] lx;
      logic signed [FIELD_W-1:0] ly;
      logic signed [FIELD_W-1:0] rx;
      logic signed [FIELD_W-1:0] ry;
      logic [TRIG_W-1:0]         lt;
      logic [TRIG_W-1:0]         rt;
      logic [FIELD_W-1:0]        buttons;
   } poll_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;

   logic                      csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_write_data = '0;

   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_link_ok = 1'b0;
   logic signed [FIELD_W-1:0] req_raw_left_x = '0;
   logic signed [FIELD_W-1:0] req_raw_left_y = '0;
   logic signed [FIELD_W-1:0] req_raw_right_x = '0;
   logic signed [FIELD_W-1:0] req_raw_right_y = '0;
   logic [TRIG_W-1:0]         req_raw_left_trigger = '0;
   logic [TRIG_W-1:0]         req_raw_right_trigger = '0;
   logic [FIELD_W-1:0]        req_button_bits = '0;

   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_connected;
   logic signed [FIELD_W-1:0] rsp_left_x_scaled;
   logic signed [FIELD_W-1:0] rsp_left_y_scaled;
   logic signed [FIELD_W-1:0] rsp_right_x_scaled;
   logic signed [FIELD_W-1:0] rsp_right_y_scaled;
   logic [FIELD_W-1:0]        rsp_left_trigger_level;
   logic [FIELD_W-1:0]        rsp_right_trigger_level;
   logic [FIELD_W-1:0]        rsp_pressed_buttons;
   logic [FIELD_W-1:0]        rsp_held_buttons;
   logic [FIELD_W-1:0]        rsp_released_buttons;
   logic [FIELD_W-1:0]        rsp_left_motor_drive;
   logic [FIELD_W-1:0]        rsp_right_motor_drive;

   int                        outstanding;
   int                        failures;

   // stimulus state: effective deadzones and the last buttons seen by the block
   int                        cur_dz_h = int'(DZ_RESET);
   int                        cur_dz_v = int'(DZ_RESET);
   logic [FIELD_W-1:0]        last_buttons = '0;
   bit                        no_idle = 1'b0;
   int                        stall_left = 0;
   int                        cycle_count = 0;

   gamepad_input_conditioner dut (.*);

   gic_checker word_check (.*);

   always #2 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   function automatic poll_type make_poll(input bit link, input int lx, input int ly,
                                          input int rx, input int ry, input int lt,
                                          input int rt, input int buttons);
      poll_type p;
      p.link    = link;
      p.lx      = FIELD_W'(lx);
      p.ly      = FIELD_W'(ly);
      p.rx      = FIELD_W'(rx);
      p.ry      = FIELD_W'(ry);
      p.lt      = TRIG_W'(lt);
      p.rt      = TRIG_W'(rt);
      p.buttons = FIELD_W'(buttons);
      return p;
   endfunction

   // axis value: full range, extremes, near the deadzone edge, or near center
   function automatic logic signed [FIELD_W-1:0] rand_axis(input int dz);
      int v;
      int corner[5] = '{-32768, -32767, 32767, 0, 1};
      case ($urandom_range(0, 4))
         0: v = corner[$urandom_range(0, 4)];
         1: begin
            v = dz + int'($urandom_range(0, 4)) - 2;
            if ($urandom_range(0, 1) == 0) v = -v;
         end
         2: v = int'($urandom_range(0, 300)) - 150;
         default: v = int'($urandom_range(0, 65535)) - 32768;
      endcase
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return FIELD_W'(v);
   endfunction

   // buttons mostly evolve from the last word so that edges and holds occur
   function automatic poll_type make_random_poll();
      poll_type p;
      p.link = ($urandom_range(0, 15) != 0);
      p.lx   = rand_axis(cur_dz_h);
      p.ly   = rand_axis(cur_dz_v);
      p.rx   = rand_axis(cur_dz_h);
      p.ry   = rand_axis(cur_dz_v);
      p.lt   = TRIG_W'($urandom);
      p.rt   = TRIG_W'($urandom);
      case ($urandom_range(0, 4))
         0: p.buttons = FIELD_W'($urandom);
         1: p.buttons = last_buttons;
         2: p.buttons = last_buttons ^ FIELD_W'($urandom & $urandom);
         default: p.buttons = last_buttons ^ (FIELD_W'(1) << $urandom_range(0, FIELD_W - 1));
      endcase
      return p;
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      int dz;
      dz = int'(data[DZ_W-1:0]);
      if (dz > int'(DZ_MAX)) dz = int'(DZ_MAX);
      if (idx == REG_DZ_H) cur_dz_h = dz;
      if (idx == REG_DZ_V) cur_dz_v = dz;
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // called at an edge; returns at the edge the word is accepted
   task automatic send_poll(input poll_type p);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_link_ok           <= p.link;
      req_raw_left_x        <= p.lx;
      req_raw_left_y        <= p.ly;
      req_raw_right_x       <= p.rx;
      req_raw_right_y       <= p.ry;
      req_raw_left_trigger  <= p.lt;
      req_raw_right_trigger <= p.rt;
      req_button_bits       <= p.buttons;
      do @(posedge clock); while (!req_ready);
      last_buttons = p.link ? p.buttons : '0;
   endtask

   // hold off the sender until every expected word has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic apply_settings(input int phase);
      case (phase)
         1: begin
            // zero deadzones, vibration on, motors at the extremes
            write_reg(REG_DZ_H, '0);
            write_reg(REG_DZ_V, '0);
            write_reg(REG_VIB_EN, CSR_DATA_W'(1));
            write_reg(REG_MOTOR_L, '1);
            write_reg(REG_MOTOR_R, '0);
         end
         2: begin
            // largest deadzone, one written above range, stray index ignored
            write_reg(REG_DZ_H, CSR_DATA_W'(DZ_MAX));
            write_reg(REG_DZ_V, '1);
            write_reg(REG_PAST_END, '1);
            write_reg(REG_MOTOR_L, '0);
            write_reg(REG_MOTOR_R, '1);
         end
         default: begin
            write_reg(REG_DZ_H, ($urandom_range(0, 2) == 0) ? CSR_DATA_W'($urandom)
                                : CSR_DATA_W'($urandom_range(0, 8000)));
            write_reg(REG_DZ_V, ($urandom_range(0, 2) == 0) ? CSR_DATA_W'($urandom)
                                : CSR_DATA_W'($urandom_range(0, 8000)));
            write_reg(REG_VIB_EN, CSR_DATA_W'($urandom));
            write_reg(REG_MOTOR_L, CSR_DATA_W'($urandom));
            write_reg(REG_MOTOR_R, CSR_DATA_W'($urandom));
            if ($urandom_range(0, 2) == 0)
               write_reg(CSR_IDX_W'($urandom_range(REG_PAST_END, (1 << CSR_IDX_W) - 1)),
                         CSR_DATA_W'($urandom));
         end
      endcase
   endtask

   // words right at and around the current deadzones
   task automatic send_corners();
      send_poll(make_poll(1, -32768, 32767, cur_dz_h, -cur_dz_v, 255, 0, 16'hFFFF));
      send_poll(make_poll(1, 32767, -32767, -(cur_dz_h + 1), cur_dz_v + 1, 0, 255, 16'h0F0F));
      send_poll(make_poll(1, cur_dz_h - 1, 1 - cur_dz_v, 0, 1, 1, 254, 16'h0000));
      send_poll(make_poll(0, 32767, -32768, 32767, -32768, 255, 255, 16'hFFFF));
   endtask

   // receiver stalls
   always @(posedge clock) begin
      if (no_idle || stall_left == 0) begin
         rsp_ready <= 1'b1;
         if (!no_idle && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end else begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("gamepad_input_conditioner: mismatch");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words under the reset settings
      send_poll(make_poll(1, 0, 0, 0, 0, 0, 0, 16'h0000));
      send_poll(make_poll(1, -32768, 32767, -32767, 32767, 255, 0, 16'hFFFF));
      send_poll(make_poll(1, 32767, -32768, 0, -32767, 0, 255, 16'hFFFF));
      send_poll(make_poll(1, 4914, 4915, -4915, -4916, 128, 1, 16'h0000));
      send_poll(make_poll(1, 4916, -4914, 1, -1, 127, 254, 16'hA5A5));
      send_poll(make_poll(1, 32766, -32767, 100, -100, 255, 255, 16'h5A5A));
      // disconnect clears the history, so the next word shows fresh presses
      send_poll(make_poll(0, 32767, 32767, -32768, 1234, 255, 255, 16'h5A5A));
      send_poll(make_poll(1, 20000, -20000, 9999, -9999, 64, 192, 16'h5A5A));
      send_poll(make_poll(1, -12345, 12345, 31129, -31130, 200, 55, 16'hFF00));
      send_poll(make_poll(0, 0, 0, 0, 0, 0, 0, 16'h0000));
      send_poll(make_poll(1, 5000, -5000, 32767, -32768, 17, 34, 16'h00FF));

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase != 0) begin
            wait_drained();
            apply_settings(phase);
         end
         if (phase == 1 || phase == 2) send_corners();
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 30 == 0) no_idle = ($urandom_range(0, 3) == 0);
            if (n == PHASE_ITEMS / 2) wait_drained();
            send_poll(make_random_poll());
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (failures == 0)
         $display("gamepad_input_conditioner: match");
      else
         $display("gamepad_input_conditioner: mismatch");
      $finish;
   end

endmodule

@@ files.f @@
rtl/gic_pkg.sv
rtl/gic_axis_lane.sv
rtl/gic_merge.sv
rtl/gamepad_input_conditioner.sv
tb/gic_checker.sv
tb/tb.sv
